// File: rtl/qrr_pkg.sv
// Shared types, constants and rounding helpers for the quaternion roll removal unit.
// Used by every module in rtl/; depends on nothing.
`default_nettype none
package qrr_pkg;

  localparam int IN_W   = 16;  // port field width
  localparam int Q30_W  = 32;  // unit vector component, Q1.30
  localparam int C22_W  = 28;  // normalizer input, Q22 before clamping

  localparam int SQRT_STEPS = 32;  // one root bit per stage
  localparam int DIV_STEPS  = 33;  // one quotient bit per stage

  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic signed [C22_W-1:0] c22_t;

  // Which branch of the shortest-arc selection an item took
  typedef struct packed {
    logic par;  // nearly parallel: identity
    logic opp;  // nearly opposite: half turn about a perpendicular axis
  } arc_flags_t;

  localparam q30_t              ONE_Q30  = 32'sd1073741824;
  localparam c22_t              Q22_LIM  = 28'sd8388608;
  localparam logic [31:0]       LEN_MIN  = 32'd5368;
  localparam logic signed [63:0] DOT_NEAR = 64'sd1073634450;
  localparam logic [Q30_W-1:0]  AY_LIMIT = 32'd966367641;
  localparam logic signed [IN_W-1:0] OUT_LIM = 16'sd16384;

  // Arithmetic shift right by s with rounding half away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  // Q30 to saturated Q14 output field
  function automatic logic [IN_W-1:0] out_q14(input q30_t v);
    logic signed [63:0] r;
    r = rnd_shift(64'(v), 16);
    if (r > 64'(OUT_LIM)) begin
      r = 64'(OUT_LIM);
    end else if (r < -64'(OUT_LIM)) begin
      r = -64'(OUT_LIM);
    end
    return r[IN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/qrr_norm.sv
// Pipelined vector normalizer: clamp, sum of squares, bit-serial square root and
// a restoring divider per lane, one bit per stage. Depends on qrr_pkg.
`default_nettype none
module qrr_norm
  import qrr_pkg::*;
#(
  parameter int N  = 4,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  c22_t          c_i [N],
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic          ok_o,
  output q30_t          u_o [N],
  output logic [SW-1:0] side_o
);

  localparam int SQ     = SQRT_STEPS;
  localparam int DV     = DIV_STEPS;
  localparam int MAG_W  = 24;
  localparam int SQR_W  = 47;
  localparam int SUM_W  = 49;
  localparam int X_W    = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 33;
  localparam int QUO_W  = 33;

  // clamp stage
  logic [MAG_W-1:0] mag_a_d [N];
  logic             sgn_a_d [N];
  logic [MAG_W-1:0] mag_a_q [N];
  logic             sgn_a_q [N];
  logic [SW-1:0]    side_a_q;
  logic             va_q;

  // square stage
  logic [SQR_W-1:0] sqr_b_q [N];
  logic [MAG_W-1:0] mag_b_q [N];
  logic             sgn_b_q [N];
  logic [SW-1:0]    side_b_q;
  logic             vb_q;
  logic [SUM_W-1:0] sum_d;

  // square root stages
  logic [REM_W-1:0]  sr_rem_q  [0:SQ];
  logic [ROOT_W-1:0] sr_root_q [0:SQ];
  logic [X_W-1:0]    sr_x_q    [0:SQ];
  logic [MAG_W-1:0]  sr_mag_q  [0:SQ][N];
  logic              sr_sgn_q  [0:SQ][N];
  logic [SW-1:0]     sr_side_q [0:SQ];
  logic              vs_q      [0:SQ];
  logic [REM_W+1:0]  sr_remn   [1:SQ];
  logic [REM_W+1:0]  sr_trial  [1:SQ];
  logic              sr_ge     [1:SQ];

  // divider stages
  logic [ROOT_W-1:0] dv_len_q  [0:DV];
  logic              dv_ok_q   [0:DV];
  logic [ROOT_W-1:0] dv_rem_q  [0:DV][N];
  logic [QUO_W-1:0]  dv_quo_q  [0:DV][N];
  logic              dv_sgn_q  [0:DV][N];
  logic [SW-1:0]     dv_side_q [0:DV];
  logic              vd_q      [0:DV];
  logic [ROOT_W:0]   dv_rem2   [1:DV][N];
  logic              dv_ge     [1:DV][N];

  // output stage
  q30_t          u_d [N];
  q30_t          u_q [N];
  logic          ok_q;
  logic [SW-1:0] side_q;
  logic          vo_q;

  // Clamp to the Q22 limit and split into magnitude and sign
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (c_i[i] > Q22_LIM) begin
        mag_a_d[i] = MAG_W'(Q22_LIM);
        sgn_a_d[i] = 1'b0;
      end else if (c_i[i] < -Q22_LIM) begin
        mag_a_d[i] = MAG_W'(Q22_LIM);
        sgn_a_d[i] = 1'b1;
      end else begin
        mag_a_d[i] = c_i[i][C22_W-1] ? MAG_W'(-c_i[i]) : MAG_W'(c_i[i]);
        sgn_a_d[i] = c_i[i][C22_W-1];
      end
    end
  end

  // Sum of squares
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < N; i++) begin
      sum_d = sum_d + SUM_W'(sqr_b_q[i]);
    end
  end

  // Root step: bring in two radicand bits, try subtracting 4r+1
  always_comb begin
    for (int k = 1; k <= SQ; k++) begin
      sr_remn[k]  = {sr_rem_q[k-1], sr_x_q[k-1][X_W-1 -: 2]};
      sr_trial[k] = {1'b0, sr_root_q[k-1], 2'b01};
      sr_ge[k]    = sr_remn[k] >= sr_trial[k];
    end
  end

  // Divide step: shift remainder, try subtracting the length
  always_comb begin
    for (int k = 1; k <= DV; k++) begin
      for (int i = 0; i < N; i++) begin
        dv_rem2[k][i] = {dv_rem_q[k-1][i], 1'b0};
        dv_ge[k][i]   = dv_rem2[k][i] >= {1'b0, dv_len_q[k-1]};
      end
    end
  end

  // Round the quotient to Q30 and restore the sign
  always_comb begin
    logic [QUO_W:0] r;
    for (int i = 0; i < N; i++) begin
      r      = {1'b0, dv_quo_q[DV][i]} + (QUO_W+1)'(1);
      u_d[i] = dv_sgn_q[DV][i] ? -q30_t'(r[QUO_W:1]) : q30_t'(r[QUO_W:1]);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
      for (int k = 0; k <= SQ; k++) vs_q[k] <= 1'b0;
      for (int k = 0; k <= DV; k++) vd_q[k] <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      vb_q    <= va_q;
      vs_q[0] <= vb_q;
      for (int k = 1; k <= SQ; k++) vs_q[k] <= vs_q[k-1];
      vd_q[0] <= vs_q[SQ];
      for (int k = 1; k <= DV; k++) vd_q[k] <= vd_q[k-1];
      vo_q    <= vd_q[DV];
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q  <= mag_a_d;
      sgn_a_q  <= sgn_a_d;
      side_a_q <= side_i;

      for (int i = 0; i < N; i++) begin
        sqr_b_q[i] <= SQR_W'(mag_a_q[i] * mag_a_q[i]);
      end
      mag_b_q  <= mag_a_q;
      sgn_b_q  <= sgn_a_q;
      side_b_q <= side_a_q;

      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
      sr_x_q[0]    <= X_W'({sum_d, 14'd0});
      sr_mag_q[0]  <= mag_b_q;
      sr_sgn_q[0]  <= sgn_b_q;
      sr_side_q[0] <= side_b_q;
      for (int k = 1; k <= SQ; k++) begin
        sr_rem_q[k]  <= sr_ge[k] ? REM_W'(sr_remn[k] - sr_trial[k])
                                 : sr_remn[k][REM_W-1:0];
        sr_root_q[k] <= {sr_root_q[k-1][ROOT_W-2:0], sr_ge[k]};
        sr_x_q[k]    <= {sr_x_q[k-1][X_W-3:0], 2'b00};
        sr_mag_q[k]  <= sr_mag_q[k-1];
        sr_sgn_q[k]  <= sr_sgn_q[k-1];
        sr_side_q[k] <= sr_side_q[k-1];
      end

      dv_len_q[0]  <= sr_root_q[SQ];
      dv_ok_q[0]   <= sr_root_q[SQ] > LEN_MIN;
      dv_side_q[0] <= sr_side_q[SQ];
      for (int i = 0; i < N; i++) begin
        dv_rem_q[0][i] <= ROOT_W'({sr_mag_q[SQ][i], 5'd0});
        dv_quo_q[0][i] <= '0;
        dv_sgn_q[0][i] <= sr_sgn_q[SQ][i];
      end
      for (int k = 1; k <= DV; k++) begin
        dv_len_q[k]  <= dv_len_q[k-1];
        dv_ok_q[k]   <= dv_ok_q[k-1];
        dv_side_q[k] <= dv_side_q[k-1];
        for (int i = 0; i < N; i++) begin
          dv_rem_q[k][i] <= dv_ge[k][i] ? ROOT_W'(dv_rem2[k][i] - {1'b0, dv_len_q[k-1]})
                                        : dv_rem2[k][i][ROOT_W-1:0];
          dv_quo_q[k][i] <= {dv_quo_q[k-1][i][QUO_W-2:0], dv_ge[k][i]};
          dv_sgn_q[k][i] <= dv_sgn_q[k-1][i];
        end
      end

      u_q    <= u_d;
      ok_q   <= dv_ok_q[DV];
      side_q <= dv_side_q[DV];
    end
  end

  assign valid_o = vo_q;
  assign ok_o    = ok_q;
  assign u_o     = u_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// File: rtl/qrr_rot.sv
// Rotates the unit bone axis by the unit quaternion: t = 2(u x a), b = a + w t + u x t.
// Five register stages; stages 1 and 3 hold the multipliers. Depends on qrr_pkg.
`default_nettype none
module qrr_rot
  import qrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  q30_t q_i [4],
  input  logic q_ok_i,
  input  q30_t a_i [3],
  input  logic a_ok_i,
  output logic valid_o,
  output c22_t c_o [3],
  output q30_t a_o [3]
);

  localparam int T_W = 34;
  localparam int S_W = 36;

  typedef logic signed [T_W-1:0] t_t;

  q30_t qe [4];
  q30_t ae [3];

  logic signed [63:0] p1_q [6];
  q30_t q1_q [4];
  q30_t a1_q [3];
  t_t   t2_q [3];
  q30_t q2_q [4];
  q30_t a2_q [3];
  logic signed [63:0] p3_q [6];
  logic signed [63:0] w3_q [3];
  q30_t a3_q [3];
  t_t   ut4_q [3];
  t_t   wt4_q [3];
  q30_t a4_q [3];
  c22_t c5_q [3];
  q30_t a5_q [3];
  logic [4:0] v_q;

  // Substitute identity / +Z for vectors that were too short
  always_comb begin
    if (q_ok_i) begin
      qe = q_i;
    end else begin
      qe = '{'0, '0, '0, ONE_Q30};
    end
    if (a_ok_i) begin
      ae = a_i;
    end else begin
      ae = '{'0, '0, ONE_Q30};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: products for u x a
      p1_q[0] <= 64'(qe[1]) * 64'(ae[2]);
      p1_q[1] <= 64'(qe[2]) * 64'(ae[1]);
      p1_q[2] <= 64'(qe[2]) * 64'(ae[0]);
      p1_q[3] <= 64'(qe[0]) * 64'(ae[2]);
      p1_q[4] <= 64'(qe[0]) * 64'(ae[1]);
      p1_q[5] <= 64'(qe[1]) * 64'(ae[0]);
      q1_q    <= qe;
      a1_q    <= ae;

      // stage 2: t = 2 (u x a)
      for (int i = 0; i < 3; i++) begin
        t2_q[i] <= T_W'(rnd_shift(p1_q[2*i] - p1_q[2*i+1], 29));
      end
      q2_q <= q1_q;
      a2_q <= a1_q;

      // stage 3: products for u x t and w t
      p3_q[0] <= 64'(q2_q[1]) * 64'(t2_q[2]);
      p3_q[1] <= 64'(q2_q[2]) * 64'(t2_q[1]);
      p3_q[2] <= 64'(q2_q[2]) * 64'(t2_q[0]);
      p3_q[3] <= 64'(q2_q[0]) * 64'(t2_q[2]);
      p3_q[4] <= 64'(q2_q[0]) * 64'(t2_q[1]);
      p3_q[5] <= 64'(q2_q[1]) * 64'(t2_q[0]);
      for (int i = 0; i < 3; i++) begin
        w3_q[i] <= 64'(q2_q[3]) * 64'(t2_q[i]);
      end
      a3_q <= a2_q;

      // stage 4: back to Q30
      for (int i = 0; i < 3; i++) begin
        ut4_q[i] <= T_W'(rnd_shift(p3_q[2*i] - p3_q[2*i+1], 30));
        wt4_q[i] <= T_W'(rnd_shift(w3_q[i], 30));
      end
      a4_q <= a3_q;

      // stage 5: sum and reduce to Q22
      for (int i = 0; i < 3; i++) begin
        c5_q[i] <= C22_W'(rnd_shift(64'(S_W'(a4_q[i]) + S_W'(wt4_q[i]) + S_W'(ut4_q[i])), 8));
      end
      a5_q <= a4_q;
    end
  end

  assign valid_o = v_q[4];
  assign c_o     = c5_q;
  assign a_o     = a5_q;

endmodule
`default_nettype wire

// File: rtl/qrr_arc.sv
// Shortest-arc setup: dot and cross product of the axis and the rotated axis,
// branch selection and the unnormalized swing quaternion. Depends on qrr_pkg.
`default_nettype none
module qrr_arc
  import qrr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  q30_t       a_i [3],
  input  q30_t       b_i [3],
  input  logic       b_ok_i,
  output logic       valid_o,
  output c22_t       c_o [4],
  output arc_flags_t flags_o
);

  localparam int D_W = 34;

  typedef logic signed [D_W-1:0] d_t;

  q30_t be [3];
  q30_t f_d [3];
  logic [Q30_W-1:0] ay_mag;

  logic signed [63:0] dp1_q [3];
  logic signed [63:0] cp1_q [6];
  q30_t f1_q [3];
  d_t   d2_q;
  d_t   cr2_q [3];
  q30_t f2_q [3];
  c22_t c3_q [4];
  arc_flags_t fl3_q;
  logic [2:0] v_q;

  logic par_d;
  logic opp_d;
  logic signed [63:0] w_d;

  // Rotated axis fallback and perpendicular helper axis
  always_comb begin
    if (b_ok_i) begin
      be = b_i;
    end else begin
      be = '{'0, '0, ONE_Q30};
    end
    ay_mag = a_i[1][Q30_W-1] ? Q30_W'(-a_i[1]) : Q30_W'(a_i[1]);
    if (ay_mag <= AY_LIMIT) begin
      f_d = '{a_i[2], '0, -a_i[0]};
    end else begin
      f_d = '{'0, -a_i[2], a_i[1]};
    end
  end

  // Branch decision from the dot product
  always_comb begin
    par_d = 64'(d2_q) >= DOT_NEAR;
    opp_d = 64'(d2_q) <= -DOT_NEAR;
    w_d   = 64'(ONE_Q30) + 64'(d2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: products
      for (int i = 0; i < 3; i++) begin
        dp1_q[i] <= 64'(a_i[i]) * 64'(be[i]);
      end
      cp1_q[0] <= 64'(a_i[1]) * 64'(be[2]);
      cp1_q[1] <= 64'(a_i[2]) * 64'(be[1]);
      cp1_q[2] <= 64'(a_i[2]) * 64'(be[0]);
      cp1_q[3] <= 64'(a_i[0]) * 64'(be[2]);
      cp1_q[4] <= 64'(a_i[0]) * 64'(be[1]);
      cp1_q[5] <= 64'(a_i[1]) * 64'(be[0]);
      f1_q <= f_d;

      // stage 2: dot and cross in Q30
      d2_q <= D_W'(rnd_shift(dp1_q[0] + dp1_q[1] + dp1_q[2], 30));
      for (int i = 0; i < 3; i++) begin
        cr2_q[i] <= D_W'(rnd_shift(cp1_q[2*i] - cp1_q[2*i+1], 30));
      end
      f2_q <= f1_q;

      // stage 3: pick the vector to normalize, reduce to Q22
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= opp_d ? C22_W'(rnd_shift(64'(f2_q[i]), 8))
                         : C22_W'(rnd_shift(64'(cr2_q[i]), 8));
      end
      c3_q[3]   <= opp_d ? c22_t'(0) : C22_W'(rnd_shift(w_d, 8));
      fl3_q.par <= par_d;
      fl3_q.opp <= opp_d;
    end
  end

  assign valid_o = v_q[2];
  assign c_o     = c3_q;
  assign flags_o = fl3_q;

endmodule
`default_nettype wire

// File: rtl/quaternion_roll_removal_unit.sv
// Quaternion roll removal unit: top level, stream ports and output register.
// Depends on qrr_pkg, qrr_norm, qrr_rot and qrr_arc.
//
// Takes a joint rotation quaternion and a bone axis (Q1.14) and returns the swing
// quaternion (Q1.14, saturated) with the twist about the axis removed. One
// transaction is accepted every cycle while the pipeline is not held. Four normalizers
// of 70 stages each dominate the depth (a 32-stage square root and a 33-stage divider,
// one result bit per stage), with two normalizers running side by side at the input.
// The whole pipeline advances together and holds while a result is not taken.
`default_nettype none
module quaternion_roll_removal_unit
  import qrr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // rot_x, rot_y, rot_z, rot_w, bone_x, bone_y, bone_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata   // swing_x, swing_y, swing_z, swing_w
);

  logic en;
  logic in_acc;

  c22_t rot_c  [4];
  c22_t bone_c [3];

  logic n1_v, n1_ok, n2_v, n2_ok;
  logic [0:0] n1_tag;
  logic [0:0] n2_side;
  q30_t q_u [4];
  q30_t a_u [3];

  logic r_v;
  c22_t r_c [3];
  q30_t r_a [3];

  logic n3_v, n3_ok;
  q30_t b_u [3];
  logic [3*Q30_W-1:0] a_pk_in;
  logic [3*Q30_W-1:0] a_pk_out;
  q30_t a_n3 [3];

  logic       arc_v;
  c22_t       arc_c [4];
  arc_flags_t arc_fl;

  logic       n4_v, n4_ok;
  q30_t       s_u [4];
  arc_flags_t n4_fl;

  q30_t        res [4];
  logic [63:0] tdata_d;
  logic [63:0] tdata_q;
  logic        tvalid_q;

  // Global advance: move whenever the output register is free or draining
  assign en            = !tvalid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;

  // Unpack and scale the inputs to Q22
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rot_c[i] = C22_W'($signed(s_axis_tdata[IN_W*i +: IN_W])) <<< 8;
    end
    for (int i = 0; i < 3; i++) begin
      bone_c[i] = C22_W'($signed(s_axis_tdata[IN_W*(4+i) +: IN_W])) <<< 8;
    end
  end

  qrr_norm #(.N(4), .SW(1)) u_norm_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_acc), .c_i(rot_c), .side_i(1'b1),
    .valid_o(n1_v), .ok_o(n1_ok), .u_o(q_u), .side_o(n1_tag)
  );

  qrr_norm #(.N(3), .SW(1)) u_norm_bone (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_acc), .c_i(bone_c), .side_i(1'b1),
    .valid_o(n2_v), .ok_o(n2_ok), .u_o(a_u), .side_o(n2_side)
  );

  qrr_rot u_rot (
    .clk_i, .rst_ni, .en_i(en), .valid_i(n2_v && n2_side[0]),
    .q_i(q_u), .q_ok_i(n1_ok), .a_i(a_u), .a_ok_i(n2_ok),
    .valid_o(r_v), .c_o(r_c), .a_o(r_a)
  );

  // The unit axis rides along the third normalizer
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_pk_in[Q30_W*i +: Q30_W] = r_a[i];
      a_n3[i] = q30_t'(a_pk_out[Q30_W*i +: Q30_W]);
    end
  end

  qrr_norm #(.N(3), .SW(3*Q30_W)) u_norm_rotated (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r_v), .c_i(r_c), .side_i(a_pk_in),
    .valid_o(n3_v), .ok_o(n3_ok), .u_o(b_u), .side_o(a_pk_out)
  );

  qrr_arc u_arc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(n3_v),
    .a_i(a_n3), .b_i(b_u), .b_ok_i(n3_ok),
    .valid_o(arc_v), .c_o(arc_c), .flags_o(arc_fl)
  );

  qrr_norm #(.N(4), .SW($bits(arc_flags_t))) u_norm_swing (
    .clk_i, .rst_ni, .en_i(en), .valid_i(arc_v), .c_i(arc_c), .side_i(arc_fl),
    .valid_o(n4_v), .ok_o(n4_ok), .u_o(s_u), .side_o(n4_fl)
  );

  // Final branch selection and Q14 conversion
  always_comb begin
    if (n4_fl.par) begin
      res = '{'0, '0, '0, ONE_Q30};
    end else if (n4_fl.opp) begin
      if (n4_ok) begin
        res = '{s_u[0], s_u[1], s_u[2], '0};
      end else begin
        res = '{'0, '0, ONE_Q30, '0};
      end
    end else if (n4_ok) begin
      res = s_u;
    end else begin
      res = '{'0, '0, '0, ONE_Q30};
    end
    for (int i = 0; i < 4; i++) begin
      tdata_d[IN_W*i +: IN_W] = out_q14(res[i]);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (en) begin
      tvalid_q <= n4_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;

  // The two input normalizers must stay in lockstep
  a_norm_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n1_v == n2_v) && (!n1_v || (n1_tag == n2_side)))
    else $error("input normalizers out of step");

  // A transaction cannot be both nearly parallel and nearly opposite
  a_branch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n4_v |-> !(n4_fl.par && n4_fl.opp))
    else $error("conflicting arc branch flags");

  // Saturated outputs stay within one in Q14
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0])  <= OUT_LIM) && ($signed(m_axis_tdata[15:0])  >= -OUT_LIM) &&
      ($signed(m_axis_tdata[31:16]) <= OUT_LIM) && ($signed(m_axis_tdata[31:16]) >= -OUT_LIM) &&
      ($signed(m_axis_tdata[47:32]) <= OUT_LIM) && ($signed(m_axis_tdata[47:32]) >= -OUT_LIM) &&
      ($signed(m_axis_tdata[63:48]) <= OUT_LIM) && ($signed(m_axis_tdata[63:48]) >= -OUT_LIM))
    else $error("swing component out of range");

endmodule
`default_nettype wire

// File: tb/quaternion_roll_removal_unit_checker.sv
// Swing predictor and scoreboard for the quaternion roll removal unit.
// Watches both stream channels of u_dut; no dependency beyond the clock/reset.
module quaternion_roll_removal_unit_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,   // rot_x, rot_y, rot_z, rot_w, bone_x, bone_y, bone_z
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,   // swing_x, swing_y, swing_z, swing_w
  output int           fail_cnt_o,
  output int           pending_o
);

  localparam longint UNIT_Q30  = 64'sd1073741824;
  localparam longint Q22_CLAMP = 64'sd8388608;
  localparam longint SHORT_LEN = 64'sd5368;
  localparam longint PAR_DOT   = 64'sd1073634450;
  localparam longint AY_MAX    = 64'sd966367641;
  localparam longint SAT_Q14   = 64'sd16384;

  logic [63:0] swing_q[$];

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  // shift right, rounding half away from zero
  function automatic longint rshr(longint v, int s);
    longint m;
    m = (magn(v) + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint sat(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normalize Q22 vector (n components) to Q30 unit; 0 when too short
  function automatic bit unit_q22(input longint c[4], input int n, output longint o[4]);
    longint cc[4];
    longint unsigned n2, len, q;
    n2 = 0;
    o = '{0, 0, 0, 0};
    for (int i = 0; i < n; i++) begin
      cc[i] = sat(c[i], Q22_CLAMP);
      n2 += longint'(cc[i] * cc[i]);
    end
    len = root64(n2 << 14);
    if (len <= SHORT_LEN) return 0;
    for (int i = 0; i < n; i++) begin
      q = (((longint'(magn(cc[i])) << 38) / len) + 1) >> 1;
      o[i] = cc[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic bit unit_q30(input longint c[4], input int n, output longint o[4]);
    longint r[4];
    r = '{0, 0, 0, 0};
    for (int i = 0; i < n; i++) r[i] = rshr(c[i], 8);
    return unit_q22(r, n, o);
  endfunction

  function automatic void crs(input longint p[4], input longint q[4], input int s,
                              output longint o[4]);
    o[0] = rshr(p[1] * q[2] - p[2] * q[1], s);
    o[1] = rshr(p[2] * q[0] - p[0] * q[2], s);
    o[2] = rshr(p[0] * q[1] - p[1] * q[0], s);
    o[3] = 0;
  endfunction

  // swing quaternion of one pose item
  function automatic logic [63:0] swing_of(logic [111:0] din);
    longint c[4], q[4], a[4], t[4], ut[4], b[4], res[4], f[4];
    longint d;
    logic [63:0] r;
    for (int i = 0; i < 4; i++) c[i] = longint'($signed(din[16*i +: 16])) * 256;
    if (!unit_q22(c, 4, q)) q = '{0, 0, 0, UNIT_Q30};
    c = '{0, 0, 0, 0};
    for (int i = 0; i < 3; i++) c[i] = longint'($signed(din[64 + 16*i +: 16])) * 256;
    if (!unit_q22(c, 3, a)) a = '{0, 0, UNIT_Q30, 0};
    crs(q, a, 29, t);
    crs(q, t, 30, ut);
    for (int i = 0; i < 3; i++) c[i] = a[i] + rshr(q[3] * t[i], 30) + ut[i];
    c[3] = 0;
    if (!unit_q30(c, 3, b)) b = '{0, 0, UNIT_Q30, 0};
    d = rshr(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
    if (d >= PAR_DOT) begin
      res = '{0, 0, 0, UNIT_Q30};
    end else if (d <= -PAR_DOT) begin
      if (magn(a[1]) <= AY_MAX) f = '{a[2], 0, -a[0], 0};
      else f = '{0, -a[2], a[1], 0};
      if (!unit_q30(f, 3, res)) res = '{0, 0, UNIT_Q30, 0};
      res[3] = 0;
    end else begin
      crs(a, b, 30, c);
      c[3] = UNIT_Q30 + d;
      if (!unit_q30(c, 4, res)) res = '{0, 0, 0, UNIT_Q30};
    end
    for (int i = 0; i < 4; i++) r[16*i +: 16] = 16'(sat(rshr(res[i], 16), SAT_Q14));
    return r;
  endfunction

  assign pending_o = swing_q.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin
    logic [63:0] exp_v;
    if (rst_ni && s_axis_tvalid && s_axis_tready) swing_q.push_back(swing_of(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (swing_q.size() == 0) begin
        $error("unexpected swing result %h", m_axis_tdata);
        fail_cnt_o++;
      end else begin
        exp_v = swing_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (exp_v[16*i +: 16] !== m_axis_tdata[16*i +: 16]) begin
            $error("swing_%s expected %0d actual %0d", i == 0 ? "x" : i == 1 ? "y" :
                   i == 2 ? "z" : "w", $signed(exp_v[16*i +: 16]),
                   $signed(m_axis_tdata[16*i +: 16]));
            fail_cnt_o++;
          end
        end
      end
    end
  end

endmodule

// File: tb/quaternion_roll_removal_unit_test.sv
// Stimulus and verdict for the quaternion roll removal unit.
// Depends on quaternion_roll_removal_unit and quaternion_roll_removal_unit_checker.
module quaternion_roll_removal_unit_test;

  localparam int RAND_ITEMS = 450;
  localparam int DRAIN_CYC  = 300;
  localparam int LIMIT_CYC  = 200000;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [63:0]  m_axis_tdata;
  int           fail_cnt, pending, cyc;

  quaternion_roll_removal_unit u_dut (.*);

  quaternion_roll_removal_unit_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > LIMIT_CYC) begin
      $display("quaternion_roll_removal_unit: mismatch");
      $finish;
    end
  end

  // receiver stalls: alternating ready stretches and random stall patterns
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk_i);
      if (cyc % 512 < 128) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // one input transaction, with a random gap before it when a burst ends
  int burst;
  task automatic send_pose(logic [111:0] d);
    if (burst == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst = $urandom_range(1, 20);
    end
    burst--;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [111:0] pose(int rx, int ry, int rz, int rw,
                                        int bx, int by, int bz);
    return {16'(bz), 16'(by), 16'(bx), 16'(rw), 16'(rz), 16'(ry), 16'(rx)};
  endfunction

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [111:0] d;
    burst = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: identity, zero quaternion, zero axis, opposite cases, extremes
    send_pose(pose(0, 0, 0, 16384, 0, 0, 16384));
    send_pose(pose(0, 0, 0, 0, 16384, 0, 0));
    send_pose(pose(0, 16384, 0, 0, 0, 0, 0));
    send_pose(pose(16384, 0, 0, 0, 0, 0, 16384));
    send_pose(pose(0, 0, 16384, 0, 16384, 0, 0));
    send_pose(pose(16384, 0, 0, 0, 0, 16384, 0));
    send_pose(pose(0, 0, 16384, 0, 1000, 16384, 0));
    send_pose(pose(11585, 0, 0, 11585, 0, 16384, 0));
    send_pose(pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pose(pose(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pose(pose(1, 0, 0, 0, 0, 1, 0));
    send_pose(pose(0, 0, 0, 2, 0, 0, 2));
    send_pose(pose(3000, -2000, 5000, 8000, 100, -200, 300));
    send_pose(pose(-32768, 0, 0, 0, 32767, 32767, 0));
    send_pose(pose(0, 0, 0, -16384, -16384, 0, 0));

    // random: mostly unit-ish poses, some wide values and short vectors
    for (int n = 0; n < RAND_ITEMS; n++) begin
      for (int i = 0; i < 7; i++) begin
        if ($urandom_range(0, 3) != 0) d[16*i +: 16] = 16'($signed(16'($urandom)) >>> 1);
        else d[16*i +: 16] = rnd_comp();
      end
      send_pose(d);
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (fail_cnt == 0) $display("quaternion_roll_removal_unit: match");
    else $display("quaternion_roll_removal_unit: mismatch");
    $finish;
  end

endmodule
